FILE: rtl/mti_pkg.sv
// Shared widths, constants and pipeline record types for the intercept time block.
package mti_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CW = 32;
  localparam int TW = 48;
  localparam int HW = 67;
  localparam int MW = 66;
  localparam int SQW = 66;
  localparam int RADW = 2 * SQW;
  localparam int NW = 68;
  localparam int LANES = 2;

  typedef struct packed {
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] start_z;
    logic signed [CW-1:0] target_x;
    logic signed [CW-1:0] target_y;
    logic signed [CW-1:0] target_z;
    logic signed [CW-1:0] target_vx;
    logic signed [CW-1:0] target_vy;
    logic signed [CW-1:0] target_vz;
  } qry_t;

  typedef struct packed {
    logic signed [HW-1:0] h;
    logic [MW-1:0] habs;
    logic hneg;
    logic [MW-1:0] dd;
    logic [MW-1:0] aabs;
    logic aneg;
    logic azero;
    logic discneg;
  } side_t;

  typedef struct packed {
    logic [RADW-1:0] rad;
    logic [SQW:0] rem;
    logic [SQW-1:0] root;
    side_t side;
  } sq_t;

  typedef struct packed {
    logic [LANES-1:0][NW-1:0] rem;
    logic [LANES-1:0][TW-1:0] low;
    logic [LANES-1:0][TW-1:0] q;
    logic [LANES-1:0][NW-1:0] den;
    logic [LANES-1:0] ok;
    logic [LANES-1:0] sat;
  } dv_t;

endpackage

FILE: rtl/mti_if.sv
// Request and result channel interfaces.
interface mti_query_if;
  logic valid;
  logic ready;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] start_z;
  logic signed [31:0] target_x;
  logic signed [31:0] target_y;
  logic signed [31:0] target_z;
  logic signed [31:0] target_vx;
  logic signed [31:0] target_vy;
  logic signed [31:0] target_vz;

  modport source (
    output valid, start_x, start_y, start_z, target_x, target_y, target_z,
    output target_vx, target_vy, target_vz,
    input ready
  );
  modport sink (
    input valid, start_x, start_y, start_z, target_x, target_y, target_z,
    input target_vx, target_vy, target_vz,
    output ready
  );
endinterface

interface mti_result_if;
  logic valid;
  logic ready;
  logic [47:0] intercept_time;
  logic no_intercept;
  logic time_saturated;

  modport source (output valid, intercept_time, no_intercept, time_saturated, input ready);
  modport sink (input valid, intercept_time, no_intercept, time_saturated, output ready);
endinterface

FILE: rtl/moving_target_intercept_time_top.sv
// Top level of the moving target intercept time pipeline.
// Usage:
//   query  : request channel, valid/ready, start point, target position and
//            target velocity, all signed Q16.16.
//   result : valid/ready, intercept_time (unsigned Q32.16), no_intercept and
//            time_saturated; exactly one result per request, in order.
//   speed_we / speed_wdata : write the traveller speed (Q16.16), reset 1.0.
//            Write only while no request is in flight.
// Throughput: one request per cycle while the result is not stalled.
// Pipeline: 7 front stages, one square root cell per root bit (66), 3 root
//   selection stages, one divider cell per time bit (48) with both candidate
//   roots side by side, and the output register.
// Reset clears every stage valid bit and the result valid; no clearing
//   pass is needed.
// Stall: when a result waits with ready low, the whole pipeline holds and
//   query.ready drops in the same cycle; nothing is lost or repeated.
module moving_target_intercept_time_top import mti_pkg::*; #(
  parameter int COORD_FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  mti_query_if.sink query,
  mti_result_if.source result,
  input  logic speed_we,
  input  logic [CW-1:0] speed_wdata
);

  logic en;
  logic [CW-1:0] speed;
  qry_t qin;
  logic sq_v [SQW+1];
  sq_t sq_d [SQW+1];
  logic dv_v [TW+1];
  dv_t dv_d [TW+1];
  logic vn, vp, ve;
  side_t siden;
  logic signed [NW-1:0] n0, n1;
  logic [LANES-1:0][NW-1:0] num_p, den_p;
  logic [LANES-1:0] ok_p;
  logic [LANES-1:0][NW-1:0] nabs;
  logic [LANES-1:0] okq;
  logic [NW+TW-1:0] xs [LANES];
  dv_t dv_e;
  logic [TW:0] t0, t1, best;
  logic found;

  assign en = !result.valid || result.ready;
  assign query.ready = en;

  assign qin.start_x = query.start_x;
  assign qin.start_y = query.start_y;
  assign qin.start_z = query.start_z;
  assign qin.target_x = query.target_x;
  assign qin.target_y = query.target_y;
  assign qin.target_z = query.target_z;
  assign qin.target_vx = query.target_vx;
  assign qin.target_vy = query.target_vy;
  assign qin.target_vz = query.target_vz;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed <= CW'(65536);
    end else if (speed_we) begin
      speed <= speed_wdata;
    end
  end

  mti_front u_front (
    .clk(clk), .rst(rst), .en(en),
    .vin(query.valid && query.ready), .din(qin), .speed(speed),
    .vout(sq_v[0]), .dout(sq_d[0])
  );

  for (genvar i = 0; i < SQW; i++) begin : g_sqrt
    mti_sqrt_cell u_cell (
      .clk(clk), .rst(rst), .en(en),
      .vin(sq_v[i]), .din(sq_d[i]), .vout(sq_v[i+1]), .dout(sq_d[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vn <= 1'b0;
      vp <= 1'b0;
      ve <= 1'b0;
    end else if (en) begin
      vn <= sq_v[SQW];
      vp <= vn;
      ve <= vp;
    end
  end

  always_comb begin
    nabs[0] = n0[NW-1] ? NW'(-n0) : NW'(n0);
    nabs[1] = n1[NW-1] ? NW'(-n1) : NW'(n1);
    okq[0] = !siden.discneg && ((n0 == '0) || (n0[NW-1] == siden.aneg));
    okq[1] = !siden.discneg && ((n1 == '0) || (n1[NW-1] == siden.aneg));
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      xs[l] = (NW+TW)'(num_p[l]) << COORD_FRAC_BITS;
      dv_e.rem[l] = xs[l][NW+TW-1:TW];
      dv_e.low[l] = xs[l][TW-1:0];
      dv_e.q[l] = '0;
      dv_e.den[l] = den_p[l];
      dv_e.sat[l] = (xs[l][NW+TW-1:TW] >= den_p[l]);
    end
    dv_e.ok = ok_p;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      siden <= sq_d[SQW].side;
      n0 <= $signed({sq_d[SQW].side.h[HW-1], sq_d[SQW].side.h})
          + $signed({2'b00, sq_d[SQW].root});
      n1 <= $signed({sq_d[SQW].side.h[HW-1], sq_d[SQW].side.h})
          - $signed({2'b00, sq_d[SQW].root});
      if (siden.azero) begin
        ok_p <= {1'b0, siden.hneg && (siden.dd != '0)};
        num_p[0] <= {2'b00, siden.dd};
        den_p[0] <= {1'b0, siden.habs, 1'b0};
        num_p[1] <= '0;
        den_p[1] <= '0;
      end else begin
        ok_p <= okq;
        num_p <= nabs;
        den_p[0] <= {2'b00, siden.aabs};
        den_p[1] <= {2'b00, siden.aabs};
      end
      dv_d[0] <= dv_e;
    end
  end

  assign dv_v[0] = ve;

  for (genvar i = 0; i < TW; i++) begin : g_div
    mti_div_cell u_cell (
      .clk(clk), .rst(rst), .en(en),
      .vin(dv_v[i]), .din(dv_d[i]), .vout(dv_v[i+1]), .dout(dv_d[i+1])
    );
  end

  always_comb begin
    t0 = dv_d[TW].sat[0] ? {1'b1, TW'(0)} : {1'b0, dv_d[TW].q[0]};
    t1 = dv_d[TW].sat[1] ? {1'b1, TW'(0)} : {1'b0, dv_d[TW].q[1]};
    found = |dv_d[TW].ok;
    if (dv_d[TW].ok[0] && dv_d[TW].ok[1]) begin
      best = (t0 < t1) ? t0 : t1;
    end else if (dv_d[TW].ok[0]) begin
      best = t0;
    end else begin
      best = t1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en) begin
      result.valid <= dv_v[TW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.no_intercept <= !found;
      result.time_saturated <= found && best[TW];
      if (!found) begin
        result.intercept_time <= '0;
      end else if (best[TW]) begin
        result.intercept_time <= '1;
      end else begin
        result.intercept_time <= best[TW-1:0];
      end
    end
  end

endmodule

FILE: rtl/mti_front.sv
// Front pipeline: offsets, dot products, quadratic coefficients and discriminant.
module mti_front import mti_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic vin,
  input  qry_t din,
  input  logic [CW-1:0] speed,
  output logic vout,
  output sq_t dout
);

  logic [6:0] v;
  logic signed [CW:0] d1 [3];
  logic signed [CW-1:0] w1 [3];
  logic [CW-1:0] sp1;
  logic signed [2*CW:0] dw2 [3];
  logic signed [2*CW+1:0] dd2 [3];
  logic signed [2*CW-1:0] ww2 [3];
  logic [2*CW-1:0] vv2;
  logic signed [HW-1:0] h3;
  logic [MW-1:0] dd3;
  logic signed [MW-1:0] a3;
  logic [2*CW-1:0] wws;
  side_t side4, side5, side6, side6d, side7;
  logic [32:0] hl, hh, al, ah, dl, dh;
  logic [MW-1:0] pll, plh, phh, q00, q01, q10, q11;
  logic [RADW-1:0] h2, adc, disc7;

  assign wws = $unsigned(ww2[0]) + $unsigned(ww2[1]) + $unsigned(ww2[2]);
  assign hl = side4.habs[32:0];
  assign hh = side4.habs[MW-1:33];
  assign al = side4.aabs[32:0];
  assign ah = side4.aabs[MW-1:33];
  assign dl = side4.dd[32:0];
  assign dh = side4.dd[MW-1:33];

  always_comb begin
    side6d = side6;
    side6d.discneg = side6.aneg && (h2 < adc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[5:0], vin};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1[0] <= $signed({din.target_x[CW-1], din.target_x}) - $signed({din.start_x[CW-1], din.start_x});
      d1[1] <= $signed({din.target_y[CW-1], din.target_y}) - $signed({din.start_y[CW-1], din.start_y});
      d1[2] <= $signed({din.target_z[CW-1], din.target_z}) - $signed({din.start_z[CW-1], din.start_z});
      w1[0] <= din.target_vx;
      w1[1] <= din.target_vy;
      w1[2] <= din.target_vz;
      sp1 <= speed;
      for (int k = 0; k < 3; k++) begin
        dw2[k] <= d1[k] * w1[k];
        dd2[k] <= d1[k] * d1[k];
        ww2[k] <= w1[k] * w1[k];
      end
      vv2 <= sp1 * sp1;
      h3 <= dw2[0] + dw2[1] + dw2[2];
      dd3 <= MW'($unsigned(dd2[0])) + MW'($unsigned(dd2[1])) + MW'($unsigned(dd2[2]));
      a3 <= $signed({2'b00, vv2}) - $signed({2'b00, wws});
      side4.h <= h3;
      side4.habs <= h3[HW-1] ? MW'(-h3) : MW'(h3);
      side4.hneg <= h3[HW-1];
      side4.dd <= dd3;
      side4.aabs <= a3[MW-1] ? MW'(-a3) : MW'(a3);
      side4.aneg <= a3[MW-1];
      side4.azero <= (a3 == '0);
      side4.discneg <= 1'b0;
      side5 <= side4;
      pll <= hl * hl;
      plh <= hl * hh;
      phh <= hh * hh;
      q00 <= al * dl;
      q01 <= al * dh;
      q10 <= ah * dl;
      q11 <= ah * dh;
      side6 <= side5;
      h2 <= (RADW'(phh) << 66) + (RADW'(plh) << 34) + RADW'(pll);
      adc <= (RADW'(q11) << 66) + ((RADW'(q01) + RADW'(q10)) << 33) + RADW'(q00);
      side7 <= side6d;
      if (side6.aneg) begin
        disc7 <= h2 - adc;
      end else begin
        disc7 <= h2 + adc;
      end
    end
  end

  assign vout = v[6];
  assign dout.rad = disc7;
  assign dout.rem = '0;
  assign dout.root = '0;
  assign dout.side = side7;

endmodule

FILE: rtl/mti_sqrt_cell.sv
// One cell of the square root chain: retires one root bit per stage.
module mti_sqrt_cell import mti_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic vin,
  input  sq_t  din,
  output logic vout,
  output sq_t  dout
);

  logic [SQW+2:0] r2, trial, diff;

  always_comb begin
    r2 = {din.rem, din.rad[RADW-1 -: 2]};
    trial = {1'b0, din.root, 2'b01};
    diff = r2 - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.side <= din.side;
      dout.rad <= {din.rad[RADW-3:0], 2'b00};
      if (r2 >= trial) begin
        dout.rem <= diff[SQW:0];
        dout.root <= {din.root[SQW-2:0], 1'b1};
      end else begin
        dout.rem <= r2[SQW:0];
        dout.root <= {din.root[SQW-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: rtl/mti_div_cell.sv
// One cell of the divider chain: retires one quotient bit per lane per stage.
module mti_div_cell import mti_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic vin,
  input  dv_t  din,
  output logic vout,
  output dv_t  dout
);

  logic [NW:0] r2 [LANES];
  logic [NW:0] diff [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      r2[l] = {din.rem[l], din.low[l][TW-1]};
      diff[l] = r2[l] - {1'b0, din.den[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.den <= din.den;
      dout.ok <= din.ok;
      dout.sat <= din.sat;
      for (int l = 0; l < LANES; l++) begin
        dout.low[l] <= {din.low[l][TW-2:0], 1'b0};
        if (r2[l] >= {1'b0, din.den[l]}) begin
          dout.rem[l] <= diff[l][NW-1:0];
          dout.q[l] <= {din.q[l][TW-2:0], 1'b1};
        end else begin
          dout.rem[l] <= r2[l][NW-1:0];
          dout.q[l] <= {din.q[l][TW-2:0], 1'b0};
        end
      end
    end
  end

endmodule

FILE: rtl/mti_chk.sv
// Port-level checker for the intercept time top level, with its bind.
module mti_chk (
  input logic clk,
  input logic rst,
  input logic q_ready,
  input logic r_valid,
  input logic r_ready,
  input logic [47:0] r_time,
  input logic r_none,
  input logic r_sat
);

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    r_valid && r_none |-> (r_time == '0) && !r_sat)
    else $error("no intercept result carries a time");

  a_sat_max: assert property (@(posedge clk) disable iff (rst)
    r_valid && r_sat |-> (r_time == '1) && !r_none)
    else $error("saturated result is not at full scale");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    q_ready == (!r_valid || r_ready))
    else $error("request ready does not follow result stall");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    r_valid && !r_ready |=> r_valid && $stable(r_time))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !r_valid)
    else $error("result valid right after reset");

endmodule

bind moving_target_intercept_time_top mti_chk u_chk (
  .clk(clk),
  .rst(rst),
  .q_ready(query.ready),
  .r_valid(result.valid),
  .r_ready(result.ready),
  .r_time(result.intercept_time),
  .r_none(result.no_intercept),
  .r_sat(result.time_saturated)
);

FILE: tb/sv/tb_top.sv
// Testbench for the moving target intercept time block: table-driven and random requests.
`timescale 1ns / 1ps
module tb_top;
  import mti_pkg::*;

  typedef struct {
    logic [47:0] t;
    logic ni;
    logic sat;
  } intercept_t;

  typedef struct {
    qry_t q;
    bit fixed;
    intercept_t r;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic speed_we = 1'b0;
  logic [31:0] speed_wdata = 32'd0;
  logic [31:0] speed_cur = 32'd65536;

  mti_query_if qif();
  mti_result_if rif();

  moving_target_intercept_time_top uut (
    .clk(clk), .rst(rst), .query(qif), .result(rif),
    .speed_we(speed_we), .speed_wdata(speed_wdata)
  );

  always #4 clk = ~clk;

  intercept_t pending_q[$];
  int errors = 0;
  int src_idle = 0;
  int snk_idle = 0;
  int hold_cycles = 0;

  function automatic logic [255:0] isqrt(logic [255:0] x);
    logic [255:0] r, c;
    r = '0;
    for (int i = 99; i >= 0; i--) begin
      c = r | (256'd1 << i);
      if (c * c <= x) r = c;
    end
    return r;
  endfunction

  function automatic logic [48:0] quot_time(logic [255:0] n, logic [255:0] d);
    logic [255:0] sc;
    sc = n << 16;
    if (sc >= (d << 48)) return 49'h1_0000_0000_0000;
    return 49'(sc / d);
  endfunction

  function automatic intercept_t solve_intercept(qry_t q, logic [31:0] spd);
    logic signed [255:0] d[3], w[3], h, dd, ww, a, disc, s, n[2];
    logic [255:0] na, aa;
    logic [48:0] best, t;
    bit found;
    intercept_t r;
    d[0] = 256'(q.target_x) - 256'(q.start_x);
    d[1] = 256'(q.target_y) - 256'(q.start_y);
    d[2] = 256'(q.target_z) - 256'(q.start_z);
    w[0] = 256'(q.target_vx);
    w[1] = 256'(q.target_vy);
    w[2] = 256'(q.target_vz);
    h = 0; dd = 0; ww = 0;
    for (int k = 0; k < 3; k++) begin
      h += d[k] * w[k];
      dd += d[k] * d[k];
      ww += w[k] * w[k];
    end
    a = $signed({224'd0, spd}) * $signed({224'd0, spd}) - ww;
    found = 0;
    best = '0;
    if (a == 0) begin
      if (h < 0 && dd != 0) begin
        best = quot_time(dd, -(h + h));
        found = 1;
      end
    end else begin
      disc = h * h + a * dd;
      if (disc >= 0) begin
        s = isqrt(disc);
        n[0] = h + s;
        n[1] = h - s;
        aa = (a < 0) ? -a : a;
        for (int k = 0; k < 2; k++) begin
          if (n[k] == 0 || ((n[k] < 0) == (a < 0))) begin
            na = (n[k] < 0) ? -n[k] : n[k];
            t = quot_time(na, aa);
            if (!found || t < best) best = t;
            found = 1;
          end
        end
      end
    end
    if (!found) begin
      r.t = '0; r.ni = 1'b1; r.sat = 1'b0;
    end else if (best[48]) begin
      r.t = '1; r.ni = 1'b0; r.sat = 1'b1;
    end else begin
      r.t = best[47:0]; r.ni = 1'b0; r.sat = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    intercept_t e;
    if (!rst && rif.valid && rif.ready) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result", rif.intercept_time, 48'd0);
      end else begin
        e = pending_q.pop_front();
        if (rif.intercept_time !== e.t) report_mismatch("intercept_time", rif.intercept_time, e.t);
        if (rif.no_intercept !== e.ni)
          report_mismatch("no_intercept", 48'(rif.no_intercept), 48'(e.ni));
        if (rif.time_saturated !== e.sat)
          report_mismatch("time_saturated", 48'(rif.time_saturated), 48'(e.sat));
      end
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      rif.ready = 1'b0;
      hold_cycles--;
    end else begin
      rif.ready = !rst && ($urandom_range(99) >= snk_idle);
    end
  end

  task automatic send_query(qry_t q, bit fixed, intercept_t r);
    qif.valid = 1'b1;
    qif.start_x = q.start_x; qif.start_y = q.start_y; qif.start_z = q.start_z;
    qif.target_x = q.target_x; qif.target_y = q.target_y; qif.target_z = q.target_z;
    qif.target_vx = q.target_vx; qif.target_vy = q.target_vy; qif.target_vz = q.target_vz;
    do @(posedge clk); while (!qif.ready);
    pending_q.push_back(fixed ? r : solve_intercept(q, speed_cur));
    @(negedge clk);
    while ($urandom_range(99) < src_idle) begin
      qif.valid = 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic drain_and_set_speed(logic [31:0] spd);
    qif.valid = 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (140) @(negedge clk);
    speed_we = 1'b1;
    speed_wdata = spd;
    @(negedge clk);
    speed_we = 1'b0;
    speed_cur = spd;
  endtask

  function automatic logic [31:0] pick_coord(int sel);
    case (sel)
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(2000000)) - 1000000);
      default: return $urandom;
    endcase
  endfunction

  function automatic qry_t random_query(logic [31:0] spd);
    qry_t q;
    int kind;
    logic [31:0] vmag;
    kind = $urandom_range(9);
    if (kind < 3) begin
      q = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom};
    end else begin
      q.start_x = pick_coord(2); q.start_y = pick_coord(2); q.start_z = pick_coord(2);
      q.target_x = pick_coord(2); q.target_y = pick_coord(2); q.target_z = pick_coord(2);
      vmag = spd >> $urandom_range(1, 4);
      if (vmag > 32'h3FFF_FFFF) vmag = 32'h3FFF_FFFF;
      q.target_vx = 32'($signed({1'b0, $urandom_range(vmag)}) * ($urandom_range(1) ? 1 : -1));
      q.target_vy = 32'($signed({1'b0, $urandom_range(vmag)}) * ($urandom_range(1) ? 1 : -1));
      q.target_vz = 32'($signed({1'b0, $urandom_range(vmag)}) * ($urandom_range(1) ? 1 : -1));
      if (kind == 3 && spd <= 32'h7FFF_FFFF) begin
        q.target_vx = $urandom_range(1) ? spd : -spd;
        q.target_vy = '0;
        q.target_vz = '0;
      end
      if (kind == 4 && $urandom_range(3) == 0) begin
        q.target_x = q.start_x; q.target_y = q.start_y; q.target_z = q.start_z;
      end
      if (kind == 5) begin
        q.start_x = pick_coord($urandom_range(3));
        q.target_x = pick_coord($urandom_range(3));
      end
    end
    return q;
  endfunction

  row_t dir_rows[$];

  task automatic add_row(qry_t q, bit fixed, logic [47:0] t, logic ni, logic sat);
    row_t r;
    r.q = q; r.fixed = fixed; r.r.t = t; r.r.ni = ni; r.r.sat = sat;
    dir_rows.push_back(r);
  endtask

  initial begin
    logic [31:0] speeds[7];
    qry_t q;
    intercept_t none;
    qif.valid = 1'b0;
    {qif.start_x, qif.start_y, qif.start_z} = '0;
    {qif.target_x, qif.target_y, qif.target_z} = '0;
    {qif.target_vx, qif.target_vy, qif.target_vz} = '0;
    none.t = '0; none.ni = 1'b0; none.sat = 1'b0;
    speeds = '{32'd0, 32'hFFFF_FFFF, 32'd131072, 32'd0, 32'd65536, 32'd0, 32'd1};
    speeds[3] = $urandom;
    speeds[5] = $urandom_range(32'h0010_0000);

    q = '0;
    add_row(q, 1, 48'd0, 1'b0, 1'b0);
    q.target_x = 32'd65536; q.target_vx = 32'd65536;
    add_row(q, 1, 48'd0, 1'b1, 1'b0);
    q.target_vx = -32'sd65536;
    add_row(q, 1, 48'd32768, 1'b0, 1'b0);
    q = '0; q.target_x = 32'd65536; q.target_vy = 32'd131072;
    add_row(q, 1, 48'd0, 1'b1, 1'b0);
    q = '0; q.target_vx = 32'd65536;
    add_row(q, 1, 48'd0, 1'b1, 1'b0);
    q = {9{32'h8000_0000}};
    add_row(q, 0, 0, 0, 0);
    q = {9{32'h7FFF_FFFF}};
    add_row(q, 0, 0, 0, 0);
    q = {32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
         32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    add_row(q, 0, 0, 0, 0);
    q = {32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
         32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    add_row(q, 0, 0, 0, 0);
    q = '0; q.start_x = 32'h8000_0000; q.target_x = 32'h7FFF_FFFF;
    q.target_vx = 32'd65536; q.target_vy = 32'd1;
    add_row(q, 0, 0, 0, 0);
    q.target_vy = 32'd0; q.target_vx = 32'd65535;
    add_row(q, 0, 0, 0, 0);
    q = '0; q.start_y = 32'h0010_0000; q.target_vz = 32'hFFFF_0000;
    add_row(q, 0, 0, 0, 0);
    q = '0; q.target_z = 32'd1; q.target_vx = 32'd1;
    add_row(q, 0, 0, 0, 0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    src_idle = 7; snk_idle = 51;
    foreach (dir_rows[i]) send_query(dir_rows[i].q, dir_rows[i].fixed, dir_rows[i].r);
    repeat (30) send_query(random_query(speed_cur), 0, none);

    for (int p = 0; p < 7; p++) begin
      drain_and_set_speed(speeds[p]);
      if (p < 2) begin
        src_idle = 7; snk_idle = 51;
      end else if (p < 4) begin
        src_idle = 51; snk_idle = 7;
      end else begin
        src_idle = 0; snk_idle = 0;
      end
      for (int n = 0; n < 280; n++) begin
        if (p == 4 && n == 40) hold_cycles = 400;
        if (p == 5 && n == 140) begin
          qif.valid = 1'b0;
          while (pending_q.size() != 0) @(negedge clk);
        end
        send_query(random_query(speed_cur), 0, none);
      end
    end

    qif.valid = 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (140) @(negedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end
endmodule

FILE: moving_target_intercept_time_top.f
rtl/mti_pkg.sv
rtl/mti_if.sv
rtl/mti_front.sv
rtl/mti_sqrt_cell.sv
rtl/mti_div_cell.sv
rtl/moving_target_intercept_time_top.sv
rtl/mti_chk.sv
tb/sv/tb_top.sv
